/* sv/htsf_pkg.sv */
// Shared types and constants for the HTML tag strip text filter.
package htsf_pkg;

	// Character codes the filter reacts to.
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_S_LO  = 8'h73;
	localparam logic [7:0] CH_S_UP  = 8'h53;
	localparam logic [7:0] CH_C_LO  = 8'h63;
	localparam logic [7:0] CH_C_UP  = 8'h43;
	localparam logic [7:0] CH_T_LO  = 8'h74;
	localparam logic [7:0] CH_T_UP  = 8'h54;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Field widths.
	localparam int unsigned CAP_W   = 14;
	localparam int unsigned COUNT_W = 13;

	// Largest capacity honored; larger values clamp to it.
	localparam logic [CAP_W-1:0] CAP_MAX = 14'd8192;
	localparam logic [COUNT_W-1:0] LIMIT_MAX = 13'd8191;

	// Tag name check phase. Code 3 is unused and behaves as no check.
	typedef logic [1:0] peek_t;
	localparam peek_t PEEK_NONE   = 2'd0;
	localparam peek_t PEEK_FIRST  = 2'd1;
	localparam peek_t PEEK_SECOND = 2'd2;

	// Filter state carried from one byte to the next.
	typedef struct packed {
		logic                inside_tag;
		logic                drop_text;
		logic                prev_newline;
		logic                prev_space;
		peek_t               peek_phase;
		logic [COUNT_W-1:0]  emitted_count;
	} filt_state_t;

	localparam filt_state_t STATE_CLEAR = '{
		inside_tag:    1'b0,
		drop_text:     1'b0,
		prev_newline:  1'b1,
		prev_space:    1'b1,
		peek_phase:    PEEK_NONE,
		emitted_count: '0
	};

	// Result produced by one input byte.
	typedef struct packed {
		logic       valid;
		logic [7:0] out_char;
		logic       text_end;
	} filt_result_t;

endpackage

/* sv/htsf_step.sv */
// Next-state and result logic for one input byte of the text filter.
module htsf_step (
	input  htsf_pkg::filt_state_t          state,
	input  logic [7:0]                     in_byte,
	input  logic                           room_ahead,
	input  logic                           body_end,
	input  logic [htsf_pkg::COUNT_W-1:0]   emit_limit,
	output htsf_pkg::filt_state_t          state_next,
	output htsf_pkg::filt_result_t         result
);
	import htsf_pkg::*;

	filt_state_t upd;
	logic        emit;
	logic [7:0]  emit_char;

	// Tag tracking, script/style check and whitespace collapsing.
	always_comb begin
		upd       = state;
		emit      = 1'b0;
		emit_char = CH_NUL;
		if (state.emitted_count < emit_limit) begin
			// Resolve a pending tag name check with this byte.
			unique case (state.peek_phase)
				PEEK_FIRST: begin
					if (in_byte == CH_S_LO || in_byte == CH_S_UP) begin
						upd.peek_phase = PEEK_SECOND;
					end else begin
						if (in_byte == CH_SLASH) begin
							upd.drop_text = 1'b0;
						end
						upd.peek_phase = PEEK_NONE;
					end
				end
				PEEK_SECOND: begin
					if (in_byte == CH_C_LO || in_byte == CH_C_UP ||
					    in_byte == CH_T_LO || in_byte == CH_T_UP) begin
						upd.drop_text = 1'b1;
					end
					upd.peek_phase = PEEK_NONE;
				end
				default: begin
					upd.peek_phase = PEEK_NONE;
				end
			endcase

			// Classify the byte itself.
			priority if (in_byte == CH_LT) begin
				upd.inside_tag = 1'b1;
				if (room_ahead) begin
					upd.peek_phase = PEEK_FIRST;
				end
			end else if (in_byte == CH_GT) begin
				upd.inside_tag = 1'b0;
			end else if (state.inside_tag || upd.drop_text || in_byte == CH_CR) begin
				// Dropped byte.
			end else if (in_byte == CH_LF) begin
				if (!state.prev_newline) begin
					emit             = 1'b1;
					emit_char        = CH_LF;
					upd.prev_newline = 1'b1;
					upd.prev_space   = 1'b1;
				end
			end else if (in_byte == CH_SPACE || in_byte == CH_TAB) begin
				if (!state.prev_space) begin
					emit           = 1'b1;
					emit_char      = CH_SPACE;
					upd.prev_space = 1'b1;
				end
			end else begin
				emit             = 1'b1;
				emit_char        = in_byte;
				upd.prev_space   = 1'b0;
				upd.prev_newline = 1'b0;
			end

			if (emit) begin
				upd.emitted_count = state.emitted_count + 1'b1;
			end
		end
	end

	// The final byte always yields an item and clears the state.
	always_comb begin
		state_next      = body_end ? STATE_CLEAR : upd;
		result.valid    = emit | body_end;
		result.out_char = emit ? emit_char : CH_NUL;
		result.text_end = body_end;
	end

endmodule

/* sv/html_tag_strip_text_filter.sv */
// Top level of the HTML tag strip text filter: state, output stage and config.
// A result is registered in the result register, or in the skid register while the
// output is stalled. One byte per cycle while in_stall is low; the filter state
// updates once per accepted byte. A two-entry output stage (result register plus skid
// register) lets bytes keep flowing while the output is stalled, until the skid fills.
// Reset clears the filter state and output stage, and sets the capacity to 8192.
module html_tag_strip_text_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [htsf_pkg::CAP_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          room_ahead,
	input  logic                          body_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_char,
	output logic                          text_end
);
	import htsf_pkg::*;

	filt_state_t        state_q;
	filt_state_t        state_next;
	filt_result_t       step_res;
	logic [COUNT_W-1:0] limit_q;
	logic [COUNT_W-1:0] limit_wr;
	logic               in_accept;
	logic               out_take;
	logic               push;
	logic               out_valid_q;
	logic [7:0]         out_char_q;
	logic               text_end_q;
	logic               skid_valid_q;
	logic [7:0]         skid_char_q;
	logic               skid_end_q;

	// Emit limit derived from the written capacity: clamp, then minus one; zero stays zero.
	always_comb begin
		priority if (cfg_wdata > CAP_MAX) begin
			limit_wr = LIMIT_MAX;
		end else if (cfg_wdata == '0) begin
			limit_wr = '0;
		end else begin
			limit_wr = COUNT_W'(cfg_wdata - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_MAX;
		end else if (cfg_we) begin
			limit_q <= limit_wr;
		end
	end

	htsf_step u_step (
		.state      (state_q),
		.in_byte    (in_byte),
		.room_ahead (room_ahead),
		.body_end   (body_end),
		.emit_limit (limit_q),
		.state_next (state_next),
		.result     (step_res)
	);

	// Handshake: input stalls only while the skid register holds a result.
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid & ~in_stall;
	assign out_take  = out_valid_q & ~out_stall;
	assign push      = in_accept & step_res.valid;

	// Filter state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (in_accept) begin
			state_q <= state_next;
		end
	end

	// Output stage control: result register fed by the step logic or the skid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_char_q <= skid_char_q;
				text_end_q <= skid_end_q;
			end
		end else if (push) begin
			if (out_valid_q && !out_take) begin
				skid_char_q <= step_res.out_char;
				skid_end_q  <= step_res.text_end;
			end else begin
				out_char_q <= step_res.out_char;
				text_end_q <= step_res.text_end;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign text_end  = text_end_q;

	// The skid register is only ever filled behind a held result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output is empty");

	// An empty output stage cannot have a skid entry in the next cycle.
	a_skid_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |=> !skid_valid_q)
		else $error("skid register filled while the output register was free");

	// The final byte of a body clears the filter state.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && body_end |=> state_q == STATE_CLEAR)
		else $error("filter state not cleared after the final byte");

	// A transaction that ends a body always produces a result item.
	a_end_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && body_end |=> out_valid_q)
		else $error("final byte accepted without a result item");

endmodule

/* test/tb.sv */
// Testbench for the HTML tag strip text filter: directed table, random pages, predicted text.
module tb;
	import htsf_pkg::*;

	// One accepted input transaction and one text transaction.
	typedef struct packed {
		logic [7:0] ch;
		logic       room;
		logic       last;
	} page_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_item_t;

	// A directed row; typed rows carry the text item they must produce.
	typedef struct packed {
		page_byte_t stim;
		logic       typed;
		logic       has_text;
		text_item_t text;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 24;
	localparam int PHASES = 11;
	localparam int PHASE_ITEMS = 45;

	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_B_LO = 8'h62;
	localparam logic [7:0] CH_K_LO = 8'h6B;
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_FF   = 8'hFF;

	localparam text_item_t NO_TEXT = '{ch: CH_NUL, fin: 1'b0};

	// Opening stimulus: whitespace folding, tags, script dropping and body ends.
	localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
		'{'{CH_A_UP,  1'b0, 1'b0}, 1'b1, 1'b1, '{CH_A_UP, 1'b0}},
		'{'{CH_NUL,   1'b0, 1'b0}, 1'b1, 1'b1, '{CH_NUL, 1'b0}},
		'{'{CH_FF,    1'b0, 1'b0}, 1'b1, 1'b1, '{CH_FF, 1'b0}},
		'{'{CH_SPACE, 1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_TAB,   1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_CR,    1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_LF,    1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_LF,    1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_LT,    1'b1, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_S_UP,  1'b1, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_T_UP,  1'b1, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_GT,    1'b1, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_X_LO,  1'b1, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_LT,    1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_SLASH, 1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_GT,    1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_X_LO,  1'b1, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_LT,    1'b1, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_SLASH, 1'b1, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_GT,    1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_B_LO,  1'b0, 1'b0}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_BANG,  1'b0, 1'b1}, 1'b0, 1'b0, NO_TEXT},
		'{'{CH_LF,    1'b0, 1'b1}, 1'b1, 1'b1, '{CH_NUL, 1'b1}},
		'{'{CH_K_LO,  1'b0, 1'b1}, 1'b1, 1'b1, '{CH_K_LO, 1'b1}}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       in_byte = '0;
	logic             room_ahead = 1'b0;
	logic             body_end = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       out_char;
	logic             text_end;

	// Mirror of the filter state and capacity, and the text still owed.
	filt_state_t      filt_mirror = STATE_CLEAR;
	logic [CAP_W-1:0] cap_mirror = CAP_MAX;
	text_item_t       text_expect_q [$];
	logic [7:0]       page_text [$];
	text_item_t       seen_want;
	int unsigned      mismatch_count = 0;
	int unsigned      burst_left = 8;
	int unsigned      stall_cycle = 0;
	int unsigned      hold_left = 0;

	html_tag_strip_text_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.room_ahead(room_ahead),
		.body_end  (body_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.text_end  (text_end)
	);

	always #6 clk = ~clk;

	// Advance the mirrored filter by one page byte and report the text it yields.
	task automatic strip_step(input page_byte_t stim, output logic has, output text_item_t res);
		logic [CAP_W-1:0]   capv;
		logic [COUNT_W-1:0] limit;
		logic               emit;
		logic [7:0]         outc;
		capv = (cap_mirror > CAP_MAX) ? CAP_MAX : cap_mirror;
		limit = (capv == '0) ? '0 : COUNT_W'(capv - 1);
		emit = 1'b0;
		outc = CH_NUL;
		if (filt_mirror.emitted_count < limit) begin
			// Resolve a pending tag name check with this byte.
			case (filt_mirror.peek_phase)
				PEEK_FIRST: begin
					if (stim.ch == CH_S_LO || stim.ch == CH_S_UP) begin
						filt_mirror.peek_phase = PEEK_SECOND;
					end else begin
						if (stim.ch == CH_SLASH) filt_mirror.drop_text = 1'b0;
						filt_mirror.peek_phase = PEEK_NONE;
					end
				end
				PEEK_SECOND: begin
					if (stim.ch == CH_C_LO || stim.ch == CH_C_UP ||
							stim.ch == CH_T_LO || stim.ch == CH_T_UP)
						filt_mirror.drop_text = 1'b1;
					filt_mirror.peek_phase = PEEK_NONE;
				end
				default: filt_mirror.peek_phase = PEEK_NONE;
			endcase

			// Classify the byte itself.
			if (stim.ch == CH_LT) begin
				filt_mirror.inside_tag = 1'b1;
				if (stim.room) filt_mirror.peek_phase = PEEK_FIRST;
			end else if (stim.ch == CH_GT) begin
				filt_mirror.inside_tag = 1'b0;
			end else if (filt_mirror.inside_tag || filt_mirror.drop_text || stim.ch == CH_CR) begin
				// Tag bodies, dropped script text and carriage returns vanish.
			end else if (stim.ch == CH_LF) begin
				if (!filt_mirror.prev_newline) begin
					emit = 1'b1;
					outc = CH_LF;
					filt_mirror.prev_newline = 1'b1;
					filt_mirror.prev_space = 1'b1;
				end
			end else if (stim.ch == CH_SPACE || stim.ch == CH_TAB) begin
				if (!filt_mirror.prev_space) begin
					emit = 1'b1;
					outc = CH_SPACE;
					filt_mirror.prev_space = 1'b1;
				end
			end else begin
				emit = 1'b1;
				outc = stim.ch;
				filt_mirror.prev_space = 1'b0;
				filt_mirror.prev_newline = 1'b0;
			end
			if (emit) filt_mirror.emitted_count = filt_mirror.emitted_count + 1'b1;
		end

		// The final byte always yields the end item and clears the state.
		has = emit || stim.last;
		res.ch = emit ? outc : CH_NUL;
		res.fin = stim.last;
		if (stim.last) filt_mirror = STATE_CLEAR;
	endtask

	// Offer one byte, wait for its transaction, and queue the text it owes.
	task automatic send_byte(input page_byte_t stim, input logic typed, input logic typed_has,
			input text_item_t typed_text);
		logic       has;
		text_item_t pred;
		in_valid <= 1'b1;
		in_byte <= stim.ch;
		room_ahead <= stim.room;
		body_end <= stim.last;
		do @(posedge clk); while (!(in_valid && !in_stall));
		strip_step(stim, has, pred);
		if (typed) begin
			has = typed_has;
			pred = typed_text;
		end
		if (has) text_expect_q.push_back(pred);
	endtask

	// Bursts of random length separated by random gaps.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and let the filter drain, including bytes that yield no text.
	task automatic settle();
		in_valid <= 1'b0;
		while (text_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_mirror = cap;
	endtask

	// Append one piece of page content: words, whitespace, tags or script blocks.
	task automatic add_token();
		int unsigned n;
		logic [7:0]  pick [4];
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				n = $urandom_range(1, 6);
				repeat (n) page_text.push_back($urandom_range(0, 1) ?
					8'(8'h61 + $urandom_range(0, 25)) : 8'(8'h41 + $urandom_range(0, 25)));
			end
			3, 4: begin
				pick = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
				n = $urandom_range(1, 4);
				repeat (n) page_text.push_back(pick[$urandom_range(0, 3)]);
			end
			5: begin
				page_text.push_back(CH_LT);
				if ($urandom_range(0, 1)) page_text.push_back(CH_SLASH);
				n = $urandom_range(1, 4);
				repeat (n) page_text.push_back(8'(8'h61 + $urandom_range(0, 25)));
				page_text.push_back(CH_GT);
			end
			6: begin
				pick = '{CH_C_LO, CH_C_UP, CH_T_LO, CH_T_UP};
				page_text.push_back(CH_LT);
				page_text.push_back($urandom_range(0, 1) ? CH_S_LO : CH_S_UP);
				page_text.push_back(pick[$urandom_range(0, 3)]);
				page_text.push_back(CH_X_LO);
				page_text.push_back(CH_GT);
			end
			7: begin
				page_text.push_back(CH_LT);
				page_text.push_back(CH_SLASH);
				page_text.push_back(CH_S_LO);
				page_text.push_back(CH_GT);
			end
			8: begin
				// Near misses on the tag name check.
				page_text.push_back(CH_LT);
				if ($urandom_range(0, 1)) page_text.push_back(CH_S_LO);
				page_text.push_back(8'($urandom_range(0, 255)));
				page_text.push_back(CH_GT);
			end
			default: page_text.push_back(8'($urandom_range(0, 255)));
		endcase
	endtask

	// Receiver: its own stall pattern, plus long hold-offs that back up the filter.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_cycle == 500 || stall_cycle == 1400 || stall_cycle == 2600) begin
			hold_left = 90;
			out_stall <= 1'b1;
		end else begin
			case ((stall_cycle / 150) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= ((stall_cycle % 5) < 2);
			endcase
		end
		stall_cycle++;
	end

	// Compare each text transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (text_expect_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected text item, got out_char=%02h text_end=%b",
					$time, out_char, text_end);
			end else begin
				seen_want = text_expect_q.pop_front();
				if (out_char !== seen_want.ch) begin
					mismatch_count++;
					$display("%0t: out_char expected %02h, got %02h",
						$time, seen_want.ch, out_char);
				end
				if (text_end !== seen_want.fin) begin
					mismatch_count++;
					$display("%0t: text_end expected %b, got %b",
						$time, seen_want.fin, text_end);
				end
			end
		end
	end

	// Main sequence: reset, directed table, then one random phase per capacity.
	initial begin
		logic [CAP_W-1:0] cap_plan [PHASES];
		page_byte_t       stim;
		int               issued;
		int               len;
		bit               well_formed;
		bit               cut;
		cap_plan = '{14'd0, 14'd1, 14'd2, 14'd3, 14'd5, 14'h3FFF, 14'd8193, 14'd8192,
			14'd4, 14'd4, 14'd4};
		cap_plan[8] = $urandom_range(4, 60);
		cap_plan[9] = $urandom_range(100, 8191);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_byte(DIRECTED_TABLE[i].stim, DIRECTED_TABLE[i].typed,
				DIRECTED_TABLE[i].has_text, DIRECTED_TABLE[i].text);
			pace_sender();
		end
		settle();

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(cap_plan[p]);
			issued = 0;
			while (issued < PHASE_ITEMS) begin
				// Mostly well-formed pages; some are raw noise with random room flags.
				page_text.delete();
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 40);
				well_formed = ($urandom_range(0, 6) != 0);
				while (page_text.size() < len) begin
					if (well_formed) add_token();
					else page_text.push_back(8'($urandom_range(0, 255)));
				end
				// The last page of a phase may run on into the next capacity.
				cut = (issued + len >= PHASE_ITEMS) && ($urandom_range(0, 1) == 1);
				for (int i = 0; i < len; i++) begin
					stim.ch = page_text[i];
					stim.room = well_formed ? ((len - 1 - i) >= 7) : 1'($urandom_range(0, 1));
					stim.last = (i == len - 1) && !cut;
					send_byte(stim, 1'b0, 1'b0, NO_TEXT);
					pace_sender();
				end
				issued += len;
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && text_expect_q.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#3600000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
